// ===== hdl/tsq_pkg.sv =====
package tsq_pkg;

  localparam int DATA_W = 32;
  localparam int OCC_W  = 9;

  localparam logic [1:0] ACT_ENQ  = 2'd0;
  localparam logic [1:0] ACT_DEQ  = 2'd1;
  localparam logic [1:0] ACT_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [DATA_W-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_XFER,
    S_READ,
    S_DONE
  } state_t;

endpackage

// ===== hdl/two_stack_queue_top.sv =====
// FIFO queue built from two stacks held in synchronous RAMs.
// Input channel (in_valid / in_stall / in_item): action 0 enqueues data_in,
// 1 dequeues the front, 2 peeks at it; 3 does nothing. Every accepted item
// gives exactly one result item on the output channel (out_valid /
// out_stall / out_item) with data_out, status and the total occupancy.
// Result path by action:
//   enqueue, empty or full status, unused action: result registered, or held
//   in S_DONE while the receiver stalls; one item per cycle while out_stall is low.
//   dequeue or peek with a non-empty output stack: one RAM read in S_READ.
//   dequeue or peek with an empty output stack: the input stack is moved over
//   one entry per cycle in S_XFER, the last entry moved being the front.
// The transfer loop through the two RAMs sets the worst case; over a run each
// entry is moved at most once.
// in_stall is high while a dequeue or peek reads or moves entries. A finished
// result sits in the output register; while the receiver stalls the next item
// is still taken, and in_stall also stays high once a second result is ready
// before the first one leaves. Reset empties both stacks and drops any
// pending result; RAM contents are not cleared.
module two_stack_queue_top #(
  parameter int DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tsq_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tsq_pkg::out_item_t  out_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = (CW + 1 > tsq_pkg::OCC_W) ? CW + 1 : tsq_pkg::OCC_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  tsq_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]      in_cnt_r, in_cnt_nxt;
  logic [CW-1:0]      out_cnt_r, out_cnt_nxt;
  logic               is_deq_r, is_deq_nxt;
  tsq_pkg::out_item_t res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  tsq_pkg::out_item_t out_item_r, out_item_nxt;

  logic                      in_we, out_we;
  logic [AW-1:0]             in_waddr, in_raddr, out_waddr, out_raddr;
  logic [tsq_pkg::DATA_W-1:0] in_wdata, in_rdata, out_wdata, out_rdata;

  logic [CW-1:0]      in_top, out_top;
  logic               accept, out_free, fin;
  tsq_pkg::out_item_t fin_item;
  logic [SW-1:0]      occ_sum;

  tsq_ram #(.WIDTH(tsq_pkg::DATA_W), .DEPTH(DEPTH)) u_in_ram (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_waddr),
    .wdata (in_wdata),
    .raddr (in_raddr),
    .rdata (in_rdata)
  );

  tsq_ram #(.WIDTH(tsq_pkg::DATA_W), .DEPTH(DEPTH)) u_out_ram (
    .clk   (clk),
    .we    (out_we),
    .waddr (out_waddr),
    .wdata (out_wdata),
    .raddr (out_raddr),
    .rdata (out_rdata)
  );

  assign in_stall  = (state_r != tsq_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_top    = in_cnt_r - ONE_C;
  assign out_top   = out_cnt_r - ONE_C;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    state_nxt     = state_r;
    in_cnt_nxt    = in_cnt_r;
    out_cnt_nxt   = out_cnt_r;
    is_deq_nxt    = is_deq_r;
    res_nxt       = res_r;
    in_we         = 1'b0;
    in_waddr      = in_cnt_r[AW-1:0];
    in_wdata      = in_item.data_in;
    in_raddr      = in_top[AW-1:0];
    out_we        = 1'b0;
    out_waddr     = out_cnt_r[AW-1:0];
    out_wdata     = in_rdata;
    out_raddr     = out_top[AW-1:0];
    fin           = 1'b0;
    fin_item      = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;

    unique case (state_r)
      tsq_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_item.action)
            tsq_pkg::ACT_ENQ: begin
              fin = 1'b1;
              if (in_cnt_r == DEPTH_C) begin
                fin_item.status = tsq_pkg::ST_FULL;
              end else begin
                in_we      = 1'b1;
                in_cnt_nxt = in_cnt_r + ONE_C;
              end
            end
            tsq_pkg::ACT_DEQ, tsq_pkg::ACT_PEEK: begin
              is_deq_nxt = (in_item.action == tsq_pkg::ACT_DEQ);
              if (in_cnt_r == '0 && out_cnt_r == '0) begin
                fin             = 1'b1;
                fin_item.status = tsq_pkg::ST_EMPTY;
              end else if (out_cnt_r != '0) begin
                state_nxt = tsq_pkg::S_READ;
              end else begin
                in_cnt_nxt = in_top;
                state_nxt  = tsq_pkg::S_XFER;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      tsq_pkg::S_XFER: begin
        if (in_cnt_r != '0) begin
          out_we      = 1'b1;
          out_cnt_nxt = out_cnt_r + ONE_C;
          in_cnt_nxt  = in_top;
        end else begin
          // last entry moved is the front
          fin               = 1'b1;
          fin_item.data_out = in_rdata;
          if (!is_deq_r) begin
            out_we      = 1'b1;
            out_cnt_nxt = out_cnt_r + ONE_C;
          end
        end
      end
      tsq_pkg::S_READ: begin
        fin               = 1'b1;
        fin_item.data_out = out_rdata;
        if (is_deq_r) begin
          out_cnt_nxt = out_top;
        end
      end
      tsq_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = res_r;
          state_nxt     = tsq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tsq_pkg::S_IDLE;
      end
    endcase

    occ_sum            = SW'(in_cnt_nxt) + SW'(out_cnt_nxt);
    fin_item.occupancy = occ_sum[tsq_pkg::OCC_W-1:0];

    if (fin) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = fin_item;
        state_nxt     = tsq_pkg::S_IDLE;
      end else begin
        res_nxt   = fin_item;
        state_nxt = tsq_pkg::S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsq_pkg::S_IDLE;
      in_cnt_r    <= '0;
      out_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_cnt_r    <= in_cnt_nxt;
      out_cnt_r   <= out_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_deq_r   <= is_deq_nxt;
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

// ===== hdl/tsq_ram.sv =====
module tsq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/tsq_checker.sv =====
module tsq_props (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input tsq_pkg::out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result item changed");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == tsq_pkg::ST_EMPTY |->
      out_item.data_out == '0 && out_item.occupancy == '0)
    else $error("empty status with data or occupancy");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == tsq_pkg::ST_FULL |-> out_item.data_out == '0)
    else $error("full status with nonzero data");

  a_reset_clear: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result item valid right after reset");

endmodule

bind two_stack_queue_top tsq_props u_tsq_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== sim/tsq_checker.sv =====
`timescale 1ns / 1ps

module tsq_checker #(
  parameter int DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  tsq_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  tsq_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 pending
);

  localparam int DATA_W = tsq_pkg::DATA_W;
  localparam int OCC_W  = tsq_pkg::OCC_W;

  logic [DATA_W-1:0]  push_stk [DEPTH];
  logic [DATA_W-1:0]  pop_stk [DEPTH];
  int unsigned        push_cnt;
  int unsigned        pop_cnt;
  tsq_pkg::out_item_t due_results[$];

  function automatic tsq_pkg::out_item_t predict_queue_op(tsq_pkg::in_item_t item);
    tsq_pkg::out_item_t res;
    res = '0;
    res.status = tsq_pkg::ST_OK;
    case (item.action)
      tsq_pkg::ACT_ENQ: begin
        if (push_cnt >= DEPTH) begin
          res.status = tsq_pkg::ST_FULL;
        end else begin
          push_stk[push_cnt] = item.data_in;
          push_cnt++;
        end
      end
      tsq_pkg::ACT_DEQ, tsq_pkg::ACT_PEEK: begin
        if (push_cnt == 0 && pop_cnt == 0) begin
          res.status = tsq_pkg::ST_EMPTY;
        end else begin
          // refill reverses order: oldest lands on top
          if (pop_cnt == 0) begin
            while (push_cnt > 0 && pop_cnt < DEPTH) begin
              push_cnt--;
              pop_stk[pop_cnt] = push_stk[push_cnt];
              pop_cnt++;
            end
          end
          res.data_out = pop_stk[pop_cnt - 1];
          if (item.action == tsq_pkg::ACT_DEQ) begin
            pop_cnt--;
          end
        end
      end
      default: begin
      end
    endcase
    res.occupancy = OCC_W'(push_cnt + pop_cnt);
    return res;
  endfunction

  always @(posedge clk) begin
    tsq_pkg::out_item_t want;
    int                 nerr;
    if (!rst_n) begin
      push_cnt = 0;
      pop_cnt = 0;
      due_results.delete();
      pending <= 0;
      fail_count <= 0;
    end else begin
      nerr = 0;
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("result item with none expected: %h", out_item);
          nerr++;
        end else begin
          want = due_results.pop_front();
          if (out_item.data_out !== want.data_out) begin
            $error("data_out: expected %h, got %h", want.data_out, out_item.data_out);
            nerr++;
          end
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item.status);
            nerr++;
          end
          if (out_item.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, out_item.occupancy);
            nerr++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        due_results.push_back(predict_queue_op(in_item));
      end
      pending <= due_results.size();
      fail_count <= fail_count + nerr;
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int         DEPTH      = 128;
  localparam int         DATA_W     = tsq_pkg::DATA_W;
  localparam int         WATCHDOG   = 2000;
  localparam int         HOLD_LEN   = 400;
  localparam logic [1:0] ACT_NOP    = 2'd3;
  localparam int         RAND_ITEMS = 1150;
  localparam int         TAIL_ITEMS = 120;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BLEND
  } mix_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  tsq_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  tsq_pkg::out_item_t out_item;
  int                 fail_count;
  int                 pending;
  int                 quiet;
  int                 n_items;
  bit                 idle_on;
  bit                 hold_req;

  two_stack_queue_top #(.DEPTH(DEPTH)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  tsq_checker #(.DEPTH(DEPTH)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // receiver: random stall bursts, one long hold on request
  initial begin : receiver
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      2: return {1'b1, {(DATA_W-1){1'b0}}};
      3: return {1'b0, {(DATA_W-1){1'b1}}};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_action(mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  return r < 90 ? tsq_pkg::ACT_ENQ :
                        (r < 95 ? tsq_pkg::ACT_PEEK : (r < 98 ? tsq_pkg::ACT_DEQ : ACT_NOP));
      MIX_DRAIN: return r < 75 ? tsq_pkg::ACT_DEQ :
                        (r < 85 ? tsq_pkg::ACT_PEEK : (r < 97 ? tsq_pkg::ACT_ENQ : ACT_NOP));
      default:   return r < 40 ? tsq_pkg::ACT_ENQ :
                        (r < 70 ? tsq_pkg::ACT_DEQ : (r < 95 ? tsq_pkg::ACT_PEEK : ACT_NOP));
    endcase
  endfunction

  task automatic offer(input logic [1:0] act, input logic [DATA_W-1:0] val);
    in_item <= '{action: act, data_in: val};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    n_items++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    mix_t mix;
    int   span;
    n_items = 0;
    idle_on = 1'b0;
    hold_req = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_on = 1'b1;

    // empty queue, unused action, extreme values, refill and drain
    offer(tsq_pkg::ACT_PEEK, '1);
    offer(tsq_pkg::ACT_DEQ, '0);
    offer(ACT_NOP, '1);
    offer(tsq_pkg::ACT_ENQ, 32'h7FFF_FFFF);
    offer(tsq_pkg::ACT_ENQ, 32'h8000_0000);
    offer(tsq_pkg::ACT_ENQ, 32'h0000_0000);
    offer(tsq_pkg::ACT_ENQ, 32'hFFFF_FFFF);
    offer(tsq_pkg::ACT_ENQ, 32'h5555_5555);
    offer(tsq_pkg::ACT_ENQ, 32'hAAAA_AAAA);
    offer(tsq_pkg::ACT_PEEK, 32'h1234_5678);
    offer(tsq_pkg::ACT_DEQ, '0);
    offer(tsq_pkg::ACT_ENQ, 32'h0000_0001);
    offer(ACT_NOP, 32'hDEAD_BEEF);
    offer(tsq_pkg::ACT_PEEK, '0);
    repeat (6) offer(tsq_pkg::ACT_DEQ, '0);
    offer(tsq_pkg::ACT_DEQ, '1);
    offer(tsq_pkg::ACT_PEEK, '0);

    // fill both stacks to the top, overflow, then drain past empty
    hold_req = 1'b1;
    repeat (DEPTH + 2) offer(tsq_pkg::ACT_ENQ, rand_word());
    offer(tsq_pkg::ACT_PEEK, rand_word());
    repeat (DEPTH + 2) offer(tsq_pkg::ACT_ENQ, rand_word());
    repeat (2 * DEPTH + 2) offer(tsq_pkg::ACT_DEQ, rand_word());

    while (n_items < RAND_ITEMS) begin
      mix = mix_t'($urandom_range(0, 2));
      span = $urandom_range(20, 160);
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (span) offer(pick_action(mix), rand_word());
    end

    idle_on = 1'b0;
    repeat (TAIL_ITEMS) offer(pick_action(MIX_BLEND), rand_word());
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tsq_pkg.sv
hdl/tsq_ram.sv
hdl/two_stack_queue_top.sv
hdl/tsq_checker.sv
sim/tsq_checker.sv
sim/tb.sv
